FILE: src/b64e_pkg.sv
package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       message_end;
    } t_out_item;

    // One group handed from the front to the back. held_count is the number of
    // bytes that were pending before the closing byte, so the group carries
    // held_count + 1 bytes and emits held_count + 2 data characters.
    typedef struct packed {
        logic [7:0] g0;
        logic [7:0] g1;
        logic [7:0] g2;
        logic [1:0] held_count;
        logic       fin;
    } t_group;

    localparam logic [7:0] CHAR_PAD     = 8'h3d;  // '='
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;  // '+'
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;  // '/'
    localparam logic [7:0] CHAR_PERCENT = 8'h25;  // '%'
    localparam logic [7:0] CHAR_TWO     = 8'h32;  // '2'
    localparam logic [7:0] CHAR_UPPER_B = 8'h42;  // 'B'
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'

    localparam logic [1:0] ESC_STEP_PERCENT = 2'd0;
    localparam logic [1:0] ESC_STEP_TWO     = 2'd1;
    localparam logic [1:0] ESC_STEP_B       = 2'd2;

    // Standard base64 alphabet lookup.
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] v;
        logic [7:0] c;
        v = {2'b00, sextet};
        if (sextet < 6'd26) begin
            c = CHAR_UPPER_A + v;
        end else if (sextet < 6'd52) begin
            c = CHAR_LOWER_A + (v - 8'd26);
        end else if (sextet < 6'd62) begin
            c = CHAR_ZERO + (v - 8'd52);
        end else if (sextet == 6'd62) begin
            c = CHAR_PLUS;
        end else begin
            c = CHAR_SLASH;
        end
        return c;
    endfunction

endpackage

FILE: src/b64e_front.sv
module b64e_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  b64e_pkg::t_in_item i_in,
    output logic              o_push,
    output b64e_pkg::t_group  o_group,
    input  logic              i_q_full
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic       accept;
    logic       closes;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    // A byte closes a group when it is the third one or carries the final flag.
    assign closes  = (r_cnt == 2'd2) || i_in.final_byte;
    assign o_push  = accept && closes;

    always_comb begin
        o_group.held_count = r_cnt;
        o_group.fin        = i_in.final_byte;
        o_group.g0         = (r_cnt == 2'd0) ? i_in.data_byte : r_b0;
        o_group.g1         = (r_cnt == 2'd0) ? 8'd0 :
                             ((r_cnt == 2'd1) ? i_in.data_byte : r_b1);
        o_group.g2         = (r_cnt == 2'd2) ? i_in.data_byte : 8'd0;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (accept) begin
            n_cnt = closes ? 2'd0 : r_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !closes) begin
            if (r_cnt == 2'd0) begin
                r_b0 <= i_in.data_byte;
            end else begin
                r_b1 <= i_in.data_byte;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("pending byte count out of range");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full)
        else $error("group pushed into a full queue");

    a_cnt_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |=> r_cnt == 2'd0)
        else $error("pending count not cleared after group close");

endmodule

FILE: src/b64e_queue.sv
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  b64e_pkg::t_group i_data,
    output logic             o_full,
    input  logic             i_pop,
    output b64e_pkg::t_group o_data,
    output logic             o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64e_pkg::t_group r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue occupancy exceeds depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |=> o_full)
        else $error("full queue lost an entry without a pop");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !i_push) |=> !o_valid)
        else $error("empty queue gained an entry without a push");

endmodule

FILE: src/b64e_back.sv
module b64e_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_q_valid,
    input  b64e_pkg::t_group    i_q_data,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output b64e_pkg::t_out_item o_out
);

    logic                r_escape_plus;
    logic                r_busy;
    logic                n_busy;
    b64e_pkg::t_group    r_grp;
    logic [1:0]          r_idx;
    logic [1:0]          n_idx;
    logic [1:0]          r_sub;
    logic [1:0]          n_sub;
    logic                r_out_valid;
    b64e_pkg::t_out_item r_out;

    logic [5:0] sext [4];
    logic       is_data;
    logic [7:0] cur_char;
    logic       is_esc;
    logic [7:0] emit_char;
    logic       char_done;
    logic       grp_done;
    logic       adv;

    always_comb begin
        sext[0] = r_grp.g0[7:2];
        sext[1] = {r_grp.g0[1:0], r_grp.g1[7:4]};
        sext[2] = {r_grp.g1[3:0], r_grp.g2[7:6]};
        sext[3] = r_grp.g2[5:0];
    end

    // Positions up to held_count + 1 carry data; the rest are padding.
    assign is_data  = ({1'b0, r_idx} <= ({1'b0, r_grp.held_count} + 3'd1));
    assign cur_char = is_data ? b64e_pkg::b64_char(sext[r_idx]) : b64e_pkg::CHAR_PAD;
    assign is_esc   = (cur_char == b64e_pkg::CHAR_PLUS) && r_escape_plus;

    always_comb begin
        emit_char = cur_char;
        if (is_esc) begin
            case (r_sub)
                b64e_pkg::ESC_STEP_PERCENT: emit_char = b64e_pkg::CHAR_PERCENT;
                b64e_pkg::ESC_STEP_TWO:     emit_char = b64e_pkg::CHAR_TWO;
                default:                    emit_char = b64e_pkg::CHAR_UPPER_B;
            endcase
        end
    end

    assign char_done = !is_esc || (r_sub == b64e_pkg::ESC_STEP_B);
    assign grp_done  = char_done && (r_idx == 2'd3);
    assign adv       = r_busy && (!r_out_valid || i_ready);
    // The next group is taken as the current one emits its last character.
    assign o_pop     = i_q_valid && (!r_busy || (adv && grp_done));

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_sub  = r_sub;
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
            n_sub  = b64e_pkg::ESC_STEP_PERCENT;
        end else if (adv && grp_done) begin
            n_busy = 1'b0;
        end else if (adv) begin
            if (char_done) begin
                n_idx = r_idx + 2'd1;
                n_sub = b64e_pkg::ESC_STEP_PERCENT;
            end else begin
                n_sub = r_sub + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_plus <= 1'b0;
            r_busy        <= 1'b0;
            r_idx         <= 2'd0;
            r_sub         <= b64e_pkg::ESC_STEP_PERCENT;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_escape_plus <= i_cfg_data;
            end
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_sub  <= n_sub;
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_q_data;
        end
        if (adv) begin
            r_out.out_char    <= emit_char;
            r_out.message_end <= r_grp.fin && grp_done;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_sub_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub != 2'd3)
        else $error("escape step out of range");

    a_sub_only_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_sub != b64e_pkg::ESC_STEP_PERCENT) |-> is_esc)
        else $error("escape sequence running on a character that is not escaped");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (!r_busy || grp_done))
        else $error("group taken while the current one is unfinished");

    a_end_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_grp.fin && grp_done) |=> (o_valid && o_out.message_end))
        else $error("message end mark not placed on last character");

endmodule

FILE: src/base64_stream_encoder.sv
// Streaming base64 encoder with the standard alphabet. Bytes enter one per
// transfer; every third byte, or a byte with final_byte set, closes a group
// that goes through a small queue to the character generator. The input takes
// a byte every cycle while the queue has room. The output stage sends one
// character per cycle while the receiver is ready, so the character generator
// sets the sustained rate: four characters per three-byte group, and three (%2B)
// for each '+' when escape_plus is set. A final partial group is padded with
// '=' to four characters, and message_end marks the message's last character.
// The user writes escape_plus through i_cfg_we / i_cfg_data while the encoder is
// idle, unenforced by the block; it takes effect on the next character produced.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  b64e_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_ready,
    output b64e_pkg::t_out_item o_out
);

    logic             push;
    b64e_pkg::t_group push_group;
    logic             q_full;
    logic             pop;
    b64e_pkg::t_group pop_group;
    logic             q_valid;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_in     (i_in),
        .o_push   (push),
        .o_group  (push_group),
        .i_q_full (q_full)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_group),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (pop_group),
        .o_valid (q_valid)
    );

    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .i_q_data   (pop_group),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule

FILE: verif/base64_stream_encoder_test.sv
`timescale 1ns / 100ps

module base64_stream_encoder_test;

    localparam string B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int SETTLE_CYCLES = 20;
    localparam int TOTAL_ITEMS   = 310;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic                i_cfg_data;
    logic                i_valid;
    logic                o_ready;
    b64e_pkg::t_in_item  i_in;
    logic                o_valid;
    logic                i_ready;
    b64e_pkg::t_out_item o_out;

    // Local copy of the encoder state; the held bytes follow each accepted byte.
    logic       esc_plus;
    logic [1:0] held_cnt;
    logic [7:0] held_bytes [2];

    b64e_pkg::t_out_item exp_chars [$];
    int        fail_count  = 0;
    int        items_sent  = 0;
    bit        tx_no_gap   = 1'b0;
    bit        rx_steady   = 1'b0;
    int        rx_hold_req = 0;

    base64_stream_encoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Bytes that land on the '+' sextet show up often, so escapes get exercised.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'hfb;
            1: return 8'hef;
            2: return 8'hbe;
            3: return 8'hff;
            4: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void emit_char(input logic [7:0] c);
        if (c == b64e_pkg::CHAR_PLUS && esc_plus) begin
            exp_chars.push_back(b64e_pkg::t_out_item'{b64e_pkg::CHAR_PERCENT, 1'b0});
            exp_chars.push_back(b64e_pkg::t_out_item'{b64e_pkg::CHAR_TWO, 1'b0});
            exp_chars.push_back(b64e_pkg::t_out_item'{b64e_pkg::CHAR_UPPER_B, 1'b0});
        end else begin
            exp_chars.push_back(b64e_pkg::t_out_item'{c, 1'b0});
        end
    endfunction

    // Works out the characters that one accepted byte releases.
    function automatic void encode_byte(input logic [7:0] d, input logic fin);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [5:0] sx [4];
        b64e_pkg::t_out_item last;
        if (held_cnt < 2'd2 && !fin) begin
            held_bytes[held_cnt[0]] = d;
            held_cnt = held_cnt + 2'd1;
            return;
        end
        case (held_cnt)
            2'd0: begin
                b0 = d;
                b1 = 8'h00;
                b2 = 8'h00;
            end
            2'd1: begin
                b0 = held_bytes[0];
                b1 = d;
                b2 = 8'h00;
            end
            default: begin
                b0 = held_bytes[0];
                b1 = held_bytes[1];
                b2 = d;
            end
        endcase
        sx[0] = b0[7:2];
        sx[1] = {b0[1:0], b1[7:4]};
        sx[2] = {b1[3:0], b2[7:6]};
        sx[3] = b2[5:0];
        // A group of n bytes carries n + 1 data characters; the rest is padding.
        for (int i = 0; i < 4; i++) begin
            if (i <= int'(held_cnt) + 1) begin
                emit_char(B64_ALPHABET[sx[i]]);
            end else begin
                emit_char(b64e_pkg::CHAR_PAD);
            end
        end
        held_cnt = 2'd0;
        if (fin) begin
            last = exp_chars.pop_back();
            last.message_end = 1'b1;
            exp_chars.push_back(last);
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic fin);
        int gap;
        i_valid <= 1'b1;
        i_in    <= b64e_pkg::t_in_item'{d, fin};
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        encode_byte(d, fin);
        items_sent++;
        gap = tx_no_gap ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap_len());
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_byte(), i == len - 1);
        end
    endtask

    // Lets the encoder run dry; a byte that released nothing may still be inside.
    task automatic settle();
        i_valid <= 1'b0;
        while (exp_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_escape(input logic v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        esc_plus = v;
    endtask

    task automatic test_plain_groups();
        write_escape(1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7f, 1'b0);
        send_byte(8'h80, 1'b1);
        // A full group closes without the final flag, then a single byte pads.
        send_byte(8'h01, 1'b0);
        send_byte(8'hfb, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbe, 1'b1);
        settle();
    endtask

    task automatic test_escape_plus();
        write_escape(1'b1);
        send_byte(8'hfb, 1'b0);
        send_byte(8'hef, 1'b0);
        send_byte(8'hbe, 1'b1);
        send_byte(8'hf8, 1'b1);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'hff, 1'b1);
        settle();
    endtask

    // The register changes while one byte of the message is still held.
    task automatic test_escape_change_mid_message();
        write_escape(1'b0);
        send_byte(8'hfb, 1'b0);
        settle();
        write_escape(1'b1);
        send_byte(8'he0, 1'b1);
        settle();
    endtask

    // The receiver stops for a long time while bytes keep coming, so the
    // encoder fills and holds off its input.
    task automatic test_backpressure();
        rx_hold_req = 300;
        tx_no_gap   = 1'b1;
        send_message(8);
        send_message(5);
        send_message(7);
        tx_no_gap   = 1'b0;
    endtask

    task automatic test_random_messages(input int target);
        int len;
        while (items_sent < target) begin
            len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 6) : $urandom_range(7, 24);
            send_message(len);
            if ($urandom_range(0, 7) == 0) begin
                settle();
                write_escape(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0) begin
                rx_steady = !rx_steady;
                tx_no_gap = rx_steady;
            end
        end
        rx_steady = 1'b0;
        tx_no_gap = 1'b0;
    endtask

    initial begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (rx_steady) begin
                i_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30) begin
                    stall_left = pick_gap_len();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        b64e_pkg::t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (exp_chars.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("%0t: unexpected transfer, char %02h end %0b",
                             $realtime, o_out.out_char, o_out.message_end);
                end
            end else begin
                want = exp_chars.pop_front();
                if (o_out.out_char !== want.out_char ||
                    o_out.message_end !== want.message_end) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: expected char %02h end %0b, got char %02h end %0b",
                                 $realtime, want.out_char, want.message_end,
                                 o_out.out_char, o_out.message_end);
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_valid    <= 1'b0;
        i_in       <= '0;
        esc_plus   = 1'b0;
        held_cnt   = 2'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_groups();
        test_escape_plus();
        test_escape_change_mid_message();
        test_backpressure();
        test_random_messages(TOTAL_ITEMS);
        settle();

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
verif/base64_stream_encoder_test.sv
